// ===== sv/counting_semaphore_fifo_waiters_unit_defines.svh =====
// Assertion macros shared by the semaphore unit
`ifndef COUNTING_SEMAPHORE_FIFO_WAITERS_UNIT_DEFINES_SVH
`define COUNTING_SEMAPHORE_FIFO_WAITERS_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define CSFW_ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("assertion failed");
`define CSFW_ASSERT_NXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define CSFW_ASSERT_IMP(lbl, ck, rs, ante, cons)
`define CSFW_ASSERT_NXT(lbl, ck, rs, ante, cons)
`endif

`endif

// ===== sv/csfw_pkg.sv =====
// Types and constants of the semaphore unit
package csfw_pkg;

  localparam int CFG_DATA_BITS  = 16;
  localparam int CFG_INDEX_BITS = 1;
  localparam int OUTCOME_BITS   = 3;

  localparam logic [CFG_INDEX_BITS-1:0] REG_INITIAL_COUNT = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MUTEX_MODE    = 1'd1;

  localparam logic [CFG_DATA_BITS-1:0] INIT_COUNT_RESET = 16'd1;

  localparam logic OP_ACQUIRE = 1'b0;

  localparam logic [OUTCOME_BITS-1:0] OUT_GRANTED     = 3'd0;
  localparam logic [OUTCOME_BITS-1:0] OUT_QUEUED      = 3'd1;
  localparam logic [OUTCOME_BITS-1:0] OUT_WOKE        = 3'd2;
  localparam logic [OUTCOME_BITS-1:0] OUT_INCREMENTED = 3'd3;
  localparam logic [OUTCOME_BITS-1:0] OUT_NOT_OWNER   = 3'd4;
  localparam logic [OUTCOME_BITS-1:0] OUT_FULL        = 3'd5;

  typedef struct packed {
    logic load;
    logic exec;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

endpackage

// ===== sv/csfw_req_if.sv =====
// Request channel: operation and requester id
interface csfw_req_if #(
  parameter int ID_BITS = 8
);
  logic               valid;
  logic               ready;
  logic               op;
  logic [ID_BITS-1:0] requester_id;

  modport source (output valid, output op, output requester_id, input ready);
  modport sink   (input valid, input op, input requester_id, output ready);
endinterface

// ===== sv/csfw_rsp_if.sv =====
// Response channel: outcome, woken id, count and queue level
interface csfw_rsp_if #(
  parameter int ID_BITS    = 8,
  parameter int COUNT_BITS = 16,
  parameter int WAIT_BITS  = 5
);
  logic                  valid;
  logic                  ready;
  logic [2:0]            outcome;
  logic [ID_BITS-1:0]    woken_id;
  logic [COUNT_BITS-1:0] count_now;
  logic [WAIT_BITS-1:0]  waiting_now;

  modport source (output valid, output outcome, output woken_id, output count_now,
                  output waiting_now, input ready);
  modport sink   (input valid, input outcome, input woken_id, input count_now,
                  input waiting_now, output ready);
endinterface

// ===== sv/csfw_ram.sv =====
// Generic single write port RAM with registered read
module csfw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== sv/csfw_ctrl.sv =====
// Request sequencer: accept, then execute once the output stage is free
module csfw_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   req_valid,
  output logic                   req_ready,
  input  csfw_pkg::dp_status_t   status,
  output csfw_pkg::ctrl_cmd_t    cmd
);
  import csfw_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state;
  logic state_next;

  assign req_ready = (state == S_IDLE);
  assign cmd.load  = req_valid && req_ready;
  assign cmd.exec  = (state == S_EXEC) && status.out_free;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cmd.load) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (cmd.exec) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end
endmodule

// ===== sv/csfw_dp.sv =====
// Semaphore datapath: count, wait queue, owner and output register
`include "counting_semaphore_fifo_waiters_unit_defines.svh"

module csfw_dp #(
  parameter int WAIT_DEPTH = 16,
  parameter int ID_BITS    = 8,
  parameter int COUNT_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  csfw_pkg::ctrl_cmd_t                   cmd,
  output csfw_pkg::dp_status_t                  status,
  input  logic                                  op,
  input  logic [ID_BITS-1:0]                    requester_id,
  input  logic                                  cfg_we,
  input  logic [csfw_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [csfw_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  csfw_rsp_if.source                            rsp
);
  import csfw_pkg::*;

  localparam int PTR_BITS  = $clog2(WAIT_DEPTH);
  localparam int WAIT_BITS = $clog2(WAIT_DEPTH + 1);
  localparam logic [PTR_BITS-1:0]   PTR_LAST  = PTR_BITS'(WAIT_DEPTH - 1);
  localparam logic [WAIT_BITS-1:0]  WAIT_FULL = WAIT_BITS'(WAIT_DEPTH);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  logic                  op_q;
  logic [ID_BITS-1:0]    id_q;
  logic [COUNT_BITS-1:0] count;
  logic [PTR_BITS-1:0]   head;
  logic [PTR_BITS-1:0]   tail;
  logic [WAIT_BITS-1:0]  waiting;
  logic [ID_BITS-1:0]    owner_id;
  logic                  owner_valid;
  logic                  mutex_mode;
  logic                  out_valid;

  logic [COUNT_BITS-1:0] count_next;
  logic [PTR_BITS-1:0]   head_next;
  logic [PTR_BITS-1:0]   tail_next;
  logic [WAIT_BITS-1:0]  waiting_next;
  logic [ID_BITS-1:0]    owner_id_next;
  logic                  owner_valid_next;
  logic [OUTCOME_BITS-1:0] outcome_next;
  logic [ID_BITS-1:0]    woken_next;
  logic                  push;
  logic [ID_BITS-1:0]    head_word;
  logic                  owner_ok;
  logic [31:0]           cfg_ext;

  assign cfg_ext = 32'(cfg_data);
  assign owner_ok = !mutex_mode || (owner_valid && (owner_id == id_q));

  csfw_ram #(
    .WIDTH (ID_BITS),
    .DEPTH (WAIT_DEPTH)
  ) u_wait_ram (
    .clk   (clk),
    .we    (cmd.exec && push),
    .waddr (tail),
    .wdata (id_q),
    .raddr (head),
    .rdata (head_word)
  );

  always_comb begin
    count_next       = count;
    head_next        = head;
    tail_next        = tail;
    waiting_next     = waiting;
    owner_id_next    = owner_id;
    owner_valid_next = owner_valid;
    woken_next       = '0;
    push             = 1'b0;
    if (op_q == OP_ACQUIRE) begin
      priority if (count != '0) begin
        count_next   = count - 1'b1;
        outcome_next = OUT_GRANTED;
        if (mutex_mode) begin
          owner_id_next    = id_q;
          owner_valid_next = 1'b1;
        end
      end else if (waiting == WAIT_FULL) begin
        outcome_next = OUT_FULL;
      end else begin
        push         = 1'b1;
        tail_next    = (tail == PTR_LAST) ? '0 : tail + 1'b1;
        waiting_next = waiting + 1'b1;
        outcome_next = OUT_QUEUED;
      end
    end else begin
      priority if (!owner_ok) begin
        outcome_next = OUT_NOT_OWNER;
      end else if (waiting != '0) begin
        woken_next   = head_word;
        head_next    = (head == PTR_LAST) ? '0 : head + 1'b1;
        waiting_next = waiting - 1'b1;
        outcome_next = OUT_WOKE;
        if (mutex_mode) begin
          owner_id_next    = head_word;
          owner_valid_next = 1'b1;
        end
      end else begin
        if (count != COUNT_MAX) begin
          count_next = count + 1'b1;
        end
        outcome_next = OUT_INCREMENTED;
        if (mutex_mode) begin
          owner_valid_next = 1'b0;
        end
      end
    end
  end

  assign status.out_free = !out_valid || rsp.ready;
  assign rsp.valid = out_valid;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q <= op;
      id_q <= requester_id;
    end
    if (cmd.exec) begin
      rsp.outcome     <= outcome_next;
      rsp.woken_id    <= woken_next;
      rsp.count_now   <= count_next;
      rsp.waiting_now <= waiting_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count       <= COUNT_BITS'(INIT_COUNT_RESET);
      head        <= '0;
      tail        <= '0;
      waiting     <= '0;
      owner_id    <= '0;
      owner_valid <= 1'b0;
      mutex_mode  <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cmd.exec) begin
        count       <= count_next;
        head        <= head_next;
        tail        <= tail_next;
        waiting     <= waiting_next;
        owner_id    <= owner_id_next;
        owner_valid <= owner_valid_next;
        out_valid   <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          REG_INITIAL_COUNT: begin
            count       <= cfg_ext[COUNT_BITS-1:0];
            head        <= '0;
            tail        <= '0;
            waiting     <= '0;
            owner_id    <= '0;
            owner_valid <= 1'b0;
          end
          REG_MUTEX_MODE: mutex_mode <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  // empty and full both leave the pointers level; anything between does not
  `CSFW_ASSERT_IMP(a_ptr_level, clk, rst, (waiting == '0) || (waiting == WAIT_FULL), head == tail)
  `CSFW_ASSERT_IMP(a_ptr_apart, clk, rst, (waiting != '0) && (waiting != WAIT_FULL), head != tail)
  `CSFW_ASSERT_NXT(a_grant_dec, clk, rst,
    cmd.exec && !cfg_we && (op_q == OP_ACQUIRE) && (count != '0),
    count == $past(count) - 1'b1)
  `CSFW_ASSERT_NXT(a_exec_out, clk, rst, cmd.exec, out_valid)
endmodule

// ===== sv/counting_semaphore_fifo_waiters_unit.sv =====
// Counting semaphore with FIFO wait queue and optional mutex ownership
//
//   channel  dir  words                             handshake
//   req      in   op, requester_id                  valid/ready
//   rsp      out  outcome, woken_id, count_now,     valid/ready
//                 waiting_now
//   cfg      in   cfg_index, cfg_data               cfg_we, no wait
//
// Each request is accepted, then executed in a separate step that uses
// the registered read of the wait queue RAM at the head pointer.
// The result sits in an output register; a stalled rsp holds the execute step.
// Synchronous reset, count loads 1; the wait queue RAM needs no clearing pass.
module counting_semaphore_fifo_waiters_unit #(
  parameter int WAIT_DEPTH = 16,
  parameter int ID_BITS    = 8,
  parameter int COUNT_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  csfw_req_if.sink                            req,
  csfw_rsp_if.source                          rsp,
  input  logic                                cfg_we,
  input  logic [csfw_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [csfw_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import csfw_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;
  logic       ready;

  assign req.ready = ready;

  csfw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (ready),
    .status    (status),
    .cmd       (cmd)
  );

  csfw_dp #(
    .WAIT_DEPTH (WAIT_DEPTH),
    .ID_BITS    (ID_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .op           (req.op),
    .requester_id (req.requester_id),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .rsp          (rsp)
  );
endmodule
